// File: rtl/core/mgbm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and queue sizes for the modularity gain best-move block.
// Used by every module under rtl/core; no dependencies.
package mgbm_pkg;

	localparam int ID_W      = 24;
	localparam int DEG_W     = 24;
	localparam int TOT_W     = 28;
	localparam int WGT_W     = 24;
	localparam int GTW_W     = 28;
	// scores and products stay below 2^54 in magnitude
	localparam int SCORE_W   = 55;

	localparam int MID_DEPTH = 8;
	localparam int MID_AW    = $clog2(MID_DEPTH);
	localparam int MID_CW    = MID_AW + 1;

	localparam int OUT_DEPTH = 4;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = OUT_AW + 1;

	typedef logic signed [SCORE_W-1:0] score_t;

	typedef struct packed {
		score_t            score;
		score_t            link_prod;
		score_t            base_term;
		logic              is_home;
		logic              last;
		logic [ID_W-1:0]   tag;
		logic [ID_W-1:0]   home;
		logic [ID_W-1:0]   target;
	} mgbm_entry_t;

	typedef struct packed {
		logic              empty;
		logic [MID_CW-1:0] count;
	} mgbm_qstat_t;

	typedef struct packed {
		logic [ID_W-1:0]   node;
		logic [ID_W-1:0]   cluster;
		logic              moved;
	} mgbm_result_t;

endpackage

// File: rtl/core/mgbm_front.sv
`timescale 1ns / 1ps
// Front pipeline: accepts entry beats, forms the three products and the score.
// Depends on mgbm_pkg; admits beats only while the entry queue has room.
module mgbm_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [mgbm_pkg::ID_W-1:0]   node_tag,
	input  logic [mgbm_pkg::DEG_W-1:0]  degree,
	input  logic [mgbm_pkg::ID_W-1:0]   home_cluster,
	input  logic [mgbm_pkg::TOT_W-1:0]  home_cluster_total,
	input  logic [mgbm_pkg::ID_W-1:0]   target_cluster_id,
	input  logic [mgbm_pkg::WGT_W-1:0]  link_weight,
	input  logic [mgbm_pkg::TOT_W-1:0]  target_cluster_total,
	input  logic                        last_entry,
	input  logic [mgbm_pkg::GTW_W-1:0]  graph_wt,
	input  mgbm_pkg::mgbm_qstat_t       qstat,
	output logic                        ent_valid,
	output mgbm_pkg::mgbm_entry_t       ent
);
	import mgbm_pkg::*;

	logic                    accept;
	logic [MID_CW+1:0]       used;
	logic signed [TOT_W:0]   tt_adj;
	logic signed [TOT_W:0]   tc_adj;
	logic signed [TOT_W:0]   deg_ext;
	logic                    eq;

	logic                    v_s1, v_s2, v_s3;
	logic signed [TOT_W:0]   tt_adj_s1, tc_adj_s1;
	logic [DEG_W-1:0]        deg_s1;
	logic [WGT_W-1:0]        wgt_s1;
	logic                    home_s1, last_s1;
	logic [ID_W-1:0]         tag_s1, hc_s1, tgt_s1;

	score_t                  link_s2, tot_s2, base_s2;
	logic                    home_s2, last_s2;
	logic [ID_W-1:0]         tag_s2, hc_s2, tgt_s2;

	mgbm_entry_t             ent_s3;

	assign used   = (MID_CW+2)'(qstat.count) + (MID_CW+2)'(v_s1) + (MID_CW+2)'(v_s2)
		+ (MID_CW+2)'(v_s3);
	assign full   = used >= (MID_CW+2)'(MID_DEPTH);
	assign accept = push && !full;

	assign eq      = target_cluster_id == home_cluster;
	assign deg_ext = $signed({{(TOT_W+1-DEG_W){1'b0}}, degree});
	assign tt_adj  = $signed({1'b0, target_cluster_total}) - (eq ? deg_ext : '0);
	assign tc_adj  = $signed({1'b0, home_cluster_total}) - deg_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tt_adj_s1 <= tt_adj;
		tc_adj_s1 <= tc_adj;
		deg_s1    <= degree;
		wgt_s1    <= link_weight;
		home_s1   <= eq;
		last_s1   <= last_entry;
		tag_s1    <= node_tag;
		hc_s1     <= home_cluster;
		tgt_s1    <= target_cluster_id;

		link_s2   <= score_t'($signed({1'b0, graph_wt, 1'b0}))
			* score_t'($signed({1'b0, wgt_s1}));
		tot_s2    <= score_t'(tt_adj_s1) * score_t'($signed({1'b0, deg_s1}));
		base_s2   <= score_t'(tc_adj_s1) * score_t'($signed({1'b0, deg_s1}));
		home_s2   <= home_s1;
		last_s2   <= last_s1;
		tag_s2    <= tag_s1;
		hc_s2     <= hc_s1;
		tgt_s2    <= tgt_s1;

		ent_s3.score     <= link_s2 - tot_s2;
		ent_s3.link_prod <= link_s2;
		ent_s3.base_term <= base_s2;
		ent_s3.is_home   <= home_s2;
		ent_s3.last      <= last_s2;
		ent_s3.tag       <= tag_s2;
		ent_s3.home      <= hc_s2;
		ent_s3.target    <= tgt_s2;
	end

	assign ent_valid = v_s3;
	assign ent       = ent_s3;

endmodule

// File: rtl/core/mgbm_queue.sv
`timescale 1ns / 1ps
// Entry queue between the front pipeline and the back end.
// Depends on mgbm_pkg for the entry type and depth.
module mgbm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	input  mgbm_pkg::mgbm_entry_t push_ent,
	input  logic                  pop,
	output mgbm_pkg::mgbm_entry_t head,
	output mgbm_pkg::mgbm_qstat_t stat
);
	import mgbm_pkg::*;

	mgbm_entry_t         mem_q [MID_DEPTH];
	logic [MID_AW-1:0]   wr_q, rd_q;
	logic [MID_CW-1:0]   cnt_q;
	logic                do_pop;

	assign do_pop     = pop && (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign stat.empty = cnt_q == '0;
	assign stat.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_valid) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (push_valid && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (!push_valid && do_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) mem_q[wr_q] <= push_ent;
	end

endmodule

// File: rtl/core/mgbm_back.sv
`timescale 1ns / 1ps
// Back end: running best score per node, final gain test, result queue.
// Depends on mgbm_pkg; drains the entry queue one beat per cycle, holding a last beat while the result queue is full.
module mgbm_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mgbm_pkg::mgbm_qstat_t      qstat,
	input  mgbm_pkg::mgbm_entry_t      head,
	output logic                       qpop,
	output logic                       empty,
	input  logic                       pop,
	output logic [mgbm_pkg::ID_W-1:0]  result_node,
	output logic [mgbm_pkg::ID_W-1:0]  chosen_cluster,
	output logic                       moved
);
	import mgbm_pkg::*;

	logic                in_node_q;
	score_t              best_q, home_prod_q;
	logic [ID_W-1:0]     best_tgt_q;

	logic                first, take;
	score_t              nbest, nhp;
	logic [ID_W-1:0]     ntgt;

	logic                fin_v_s1;
	score_t              fin_best_s1, fin_base_s1;
	logic [ID_W-1:0]     fin_tag_s1, fin_home_s1, fin_tgt_s1;
	mgbm_result_t        res;

	mgbm_result_t        out_q [OUT_DEPTH];
	logic [OUT_AW-1:0]   owr_q, ord_q;
	logic [OUT_CW-1:0]   ocnt_q;
	logic                opop;

	assign qpop  = !qstat.empty
		&& (!head.last || ((OUT_CW+1)'(ocnt_q) + (OUT_CW+1)'(fin_v_s1)) < (OUT_CW+1)'(OUT_DEPTH));
	assign first = !in_node_q;
	assign take  = first || (head.score > best_q);
	assign nbest = take ? head.score : best_q;
	assign ntgt  = take ? head.target : best_tgt_q;
	assign nhp   = head.is_home ? head.link_prod : (first ? '0 : home_prod_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_node_q   <= 1'b0;
			best_q      <= '0;
			best_tgt_q  <= '0;
			home_prod_q <= '0;
			fin_v_s1    <= 1'b0;
		end else begin
			fin_v_s1 <= qpop && head.last;
			if (qpop) begin
				if (head.last) begin
					in_node_q   <= 1'b0;
					best_q      <= '0;
					best_tgt_q  <= '0;
					home_prod_q <= '0;
				end else begin
					in_node_q   <= 1'b1;
					best_q      <= nbest;
					best_tgt_q  <= ntgt;
					home_prod_q <= nhp;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_best_s1 <= nbest;
		fin_base_s1 <= nhp - head.base_term;
		fin_tag_s1  <= head.tag;
		fin_home_s1 <= head.home;
		fin_tgt_s1  <= ntgt;
	end

	always_comb begin
		res.node    = fin_tag_s1;
		res.moved   = fin_best_s1 > fin_base_s1;
		res.cluster = res.moved ? fin_tgt_s1 : fin_home_s1;
	end

	assign opop  = pop && (ocnt_q != '0);
	assign empty = ocnt_q == '0;
	assign result_node    = out_q[ord_q].node;
	assign chosen_cluster = out_q[ord_q].cluster;
	assign moved          = out_q[ord_q].moved;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (fin_v_s1) owr_q <= owr_q + 1'b1;
			if (opop) ord_q <= ord_q + 1'b1;
			if (fin_v_s1 && !opop) ocnt_q <= ocnt_q + 1'b1;
			else if (!fin_v_s1 && opop) ocnt_q <= ocnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_v_s1) out_q[owr_q] <= res;
	end

endmodule

// File: rtl/core/modularity_gain_best_move.sv
`timescale 1ns / 1ps
// Modularity gain best-move block: picks the best neighboring cluster of a node.
// Depends on mgbm_pkg, mgbm_front, mgbm_queue and mgbm_back.
//
// Input side is a queue write port: an entry beat is taken when push is high and
// full is low. A node is a run of beats closed by one with last_entry set; only
// that beat produces a result. Results come out as a queue read port: the oldest
// result sits on result_node/chosen_cluster/moved while empty is low and leaves
// on a cycle with pop high.
// Throughput: one entry per cycle unless full. Each entry crosses a three-stage
// front pipeline (adjust, two parallel multiplies plus the home term, score),
// an 8-deep entry queue and a two-stage back end (running max, gain test).
// A last entry's result reaches the result-queue head after the front stages,
// the entry queue write, the back end stage and the result queue write.
// When pop is held low the four-deep result queue fills, the back end stops
// draining the entry queue at the next last entry, and full rises once the
// entry queue cannot hold every beat in flight; no beat is ever dropped. The graph
// weight register is written by cfg_wr_en/cfg_wdata; the user must do so only while
// the block is idle (not enforced). Reset clears it, all queues and per-node state.
module modularity_gain_best_move (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [mgbm_pkg::GTW_W-1:0]  cfg_wdata,
	input  logic                        push,
	output logic                        full,
	input  logic [mgbm_pkg::ID_W-1:0]   node_tag,
	input  logic [mgbm_pkg::DEG_W-1:0]  degree,
	input  logic [mgbm_pkg::ID_W-1:0]   home_cluster,
	input  logic [mgbm_pkg::TOT_W-1:0]  home_cluster_total,
	input  logic [mgbm_pkg::ID_W-1:0]   target_cluster_id,
	input  logic [mgbm_pkg::WGT_W-1:0]  link_weight,
	input  logic [mgbm_pkg::TOT_W-1:0]  target_cluster_total,
	input  logic                        last_entry,
	output logic                        empty,
	input  logic                        pop,
	output logic [mgbm_pkg::ID_W-1:0]   result_node,
	output logic [mgbm_pkg::ID_W-1:0]   chosen_cluster,
	output logic                        moved
);
	import mgbm_pkg::*;

	logic [GTW_W-1:0]  graph_wt_q;
	logic              ent_valid;
	mgbm_entry_t       ent;
	mgbm_entry_t       head;
	mgbm_qstat_t       qstat;
	logic              qpop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			graph_wt_q <= '0;
		end else if (cfg_wr_en) begin
			graph_wt_q <= cfg_wdata;
		end
	end

	mgbm_front u_front (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.node_tag             (node_tag),
		.degree               (degree),
		.home_cluster         (home_cluster),
		.home_cluster_total   (home_cluster_total),
		.target_cluster_id    (target_cluster_id),
		.link_weight          (link_weight),
		.target_cluster_total (target_cluster_total),
		.last_entry           (last_entry),
		.graph_wt             (graph_wt_q),
		.qstat                (qstat),
		.ent_valid            (ent_valid),
		.ent                  (ent)
	);

	mgbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (ent_valid),
		.push_ent   (ent),
		.pop        (qpop),
		.head       (head),
		.stat       (qstat)
	);

	mgbm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qstat          (qstat),
		.head           (head),
		.qpop           (qpop),
		.empty          (empty),
		.pop            (pop),
		.result_node    (result_node),
		.chosen_cluster (chosen_cluster),
		.moved          (moved)
	);

endmodule
